>>> hw/rtl/dge_pkg.sv
//------------------------------------------------------------------------------
// dge_pkg
// Types and constants shared by the dependency graph engine and its testbench.
//------------------------------------------------------------------------------
package dge_pkg;

	localparam int unsigned VERTICES_DEF = 32;
	localparam int unsigned VW = 5;

	typedef enum logic [2:0] {
		FN_ADD_V   = 3'd0,
		FN_DEL_V   = 3'd1,
		FN_ADD_E   = 3'd2,
		FN_DEL_E   = 3'd3,
		FN_TEST_E  = 3'd4,
		FN_CHECK_E = 3'd5,
		FN_SORT    = 3'd6,
		FN_NOP     = 3'd7
	} func_t;

	typedef struct packed {
		logic [2:0]    func;
		logic [VW-1:0] vertex_a;
		logic [VW-1:0] vertex_b;
	} in_item_t;

	typedef struct packed {
		logic          status;
		logic          answer;
		logic [VW-1:0] vertex_out;
		logic          has_vertex;
		logic          last;
	} out_item_t;

endpackage

>>> hw/rtl/dependency_graph_engine.sv
//------------------------------------------------------------------------------
// dependency_graph_engine
// Directed graph store with edge check and depth-first topological sort.
//------------------------------------------------------------------------------
// Usage: items enter on in_valid/in_stall/in_item (func, vertex_a, vertex_b)
// and results leave on out_valid/out_stall/out_item. in_stall is high whenever
// the sequencer is not idle, so one item is taken at a time.
// An absent vertex or the unused code goes from idle straight to S_FIN,
// which passes its result on to the output register. Adding, testing or
// removing an edge reads row a in S_DEC, writes it back or takes the answer,
// and then goes to S_FIN. Adding or removing a vertex sweeps every row once
// before S_FIN. The edge check repeats a reach sweep, one row a cycle,
// until the reach set stops growing. The sort reads one adjacency row at a
// time and searches it for the first eligible successor. A sort gives one
// result per present vertex (last on the final one), or a single empty
// result. While the receiver stalls, the result register holds and the
// sequencer waits. Reset empties the graph and starts a clearing pass over
// every adjacency row before the first item is taken.
//------------------------------------------------------------------------------
module dependency_graph_engine #(
	parameter int unsigned VERTICES = dge_pkg::VERTICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dge_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output dge_pkg::out_item_t out_item
);
	import dge_pkg::*;

	localparam int unsigned AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int unsigned CW = $clog2(VERTICES + 1);

	localparam out_item_t RES_OK = '{status: 1'b0, answer: 1'b0,
		vertex_out: {VW{1'b0}}, has_vertex: 1'b0, last: 1'b1};
	localparam out_item_t RES_ABSENT = '{status: 1'b1, answer: 1'b0,
		vertex_out: {VW{1'b0}}, has_vertex: 1'b0, last: 1'b1};

	typedef enum logic [10:0] {
		S_CLR    = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_DEC    = 11'b00000000100,
		S_SWEEP  = 11'b00000001000,
		S_CHK    = 11'b00000010000,
		S_SROOT  = 11'b00000100000,
		S_SRD    = 11'b00001000000,
		S_SFIND  = 11'b00010000000,
		S_OUT    = 11'b00100000000,
		S_POP    = 11'b01000000000,
		S_FIN    = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [VERTICES-1:0] adj_mem [VERTICES];
	logic [VERTICES-1:0] rd_q;
	logic [VERTICES-1:0] present_q, visited_q, reach_q, grown_q;
	logic [AW-1:0] stk_mem [VERTICES];
	logic [CW-1:0] cur_mem [VERTICES];
	logic [AW-1:0] stk_rd_q;
	logic [CW-1:0] cur_rd_q;
	func_t         func_q;
	logic [AW-1:0] a_q, b_q, v_q;
	logic [CW-1:0] idx_q, depth_q;
	logic          rd_wait_q, fresh_q;
	out_item_t     out_q, pend_q;
	logic          out_v_q;

	// memory port controls
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [VERTICES-1:0] wdata;
	logic          s_we;
	logic [AW-1:0] s_waddr, s_raddr, s_wdata;
	logic          c_we;
	logic [CW-1:0] c_wdata;

	logic [AW-1:0] a_in, b_in;
	logic          a_ok, b_ok, in_absent;
	logic [VERTICES-1:0] abit, bbit;
	logic [AW-1:0] sweep_row;
	logic [VERTICES-1:0] grown_acc, grown_mask;
	logic [CW-1:0] cur_eff;
	logic          found, push, root_ok, sort_last;
	logic [AW-1:0] found_idx;
	logic          idx_last, out_free, out_load;

	assign a_in = AW'(in_item.vertex_a);
	assign b_in = AW'(in_item.vertex_b);
	assign a_ok = (32'(in_item.vertex_a) < VERTICES);
	assign b_ok = (32'(in_item.vertex_b) < VERTICES);
	assign in_absent = !a_ok || !present_q[a_in] ||
		(func_t'(in_item.func) != FN_DEL_V && (!b_ok || !present_q[b_in]));

	assign abit = {{(VERTICES-1){1'b0}}, 1'b1} << a_q;
	assign bbit = {{(VERTICES-1){1'b0}}, 1'b1} << b_q;

	// During a sweep rd_q holds the row one below idx_q.
	assign sweep_row = AW'(idx_q - CW'(1));
	assign grown_acc = grown_q | (((idx_q != '0) && reach_q[sweep_row]) ? rd_q : '0);
	assign grown_mask = grown_acc & (present_q | bbit);

	// A freshly pushed vertex starts its successor search at zero.
	assign cur_eff = fresh_q ? '0 : cur_rd_q;

	// first eligible successor at or above the cursor
	always_comb begin
		found = 1'b0;
		found_idx = '0;
		for (int i = VERTICES-1; i >= 0; i--) begin
			if (rd_q[i] && present_q[i] && !visited_q[i] && (CW'(i) >= cur_eff)) begin
				found = 1'b1;
				found_idx = AW'(i);
			end
		end
	end

	assign push = found && (depth_q < CW'(VERTICES));
	assign root_ok = (idx_q != CW'(VERTICES)) && present_q[idx_q[AW-1:0]] &&
		!visited_q[idx_q[AW-1:0]];
	// Popping the root with nothing left unvisited ends the sort.
	assign sort_last = (depth_q == CW'(1)) && ((present_q & ~visited_q) == '0);

	assign idx_last = (idx_q == CW'(VERTICES - 1));
	assign out_free = !out_v_q || !out_stall;
	assign out_load = out_free && (state_q == S_OUT || state_q == S_FIN);

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_v_q;
	assign out_item = out_q;

	assign s_raddr = AW'(depth_q - CW'(1));

	always_ff @(posedge clk) begin
		if (we) adj_mem[waddr] <= wdata;
		rd_q <= adj_mem[raddr];
		if (s_we) stk_mem[s_waddr] <= s_wdata;
		stk_rd_q <= stk_mem[s_raddr];
		if (c_we) cur_mem[v_q] <= c_wdata;
		cur_rd_q <= cur_mem[v_q];
	end

	always_comb begin
		we = 1'b0; waddr = idx_q[AW-1:0]; wdata = '0;
		raddr = idx_q[AW-1:0];
		s_we = 1'b0; s_waddr = depth_q[AW-1:0]; s_wdata = found_idx;
		c_we = 1'b0; c_wdata = CW'(found_idx) + CW'(1);
		unique case (state_q)
			S_CLR: we = 1'b1;
			S_SWEEP: begin
				if (idx_q != '0) begin
					we = 1'b1;
					waddr = sweep_row;
					wdata = (sweep_row == a_q) ? '0 : (rd_q & ~abit);
				end
			end
			S_DEC: begin
				raddr = a_q;
				waddr = a_q;
				if (rd_wait_q && func_q == FN_ADD_E) begin
					we = 1'b1; wdata = rd_q | bbit;
				end else if (rd_wait_q && func_q == FN_DEL_E) begin
					we = 1'b1; wdata = rd_q & ~bbit;
				end
			end
			S_SRD: raddr = v_q;
			S_SFIND: begin
				if (push) begin
					c_we = 1'b1;
					s_we = 1'b1;
				end
			end
			S_SROOT: begin
				if (root_ok) begin
					s_we = 1'b1; s_waddr = '0; s_wdata = idx_q[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q <= '0;
		end else if (out_load) begin
			out_q <= pend_q;
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q <= '0;
			present_q <= '0;
			visited_q <= '0;
			reach_q <= '0;
			grown_q <= '0;
			func_q <= FN_NOP;
			a_q <= '0;
			b_q <= '0;
			v_q <= '0;
			depth_q <= '0;
			rd_wait_q <= 1'b0;
			fresh_q <= 1'b0;
			pend_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					if (idx_last) begin
						idx_q <= '0;
						state_q <= S_IDLE;
					end else idx_q <= idx_q + CW'(1);
				end
				S_IDLE: if (in_valid) begin
					func_q <= func_t'(in_item.func);
					a_q <= a_in;
					b_q <= b_in;
					idx_q <= '0;
					rd_wait_q <= 1'b0;
					unique case (func_t'(in_item.func)) inside
						FN_ADD_V: begin
							if (!a_ok) begin
								pend_q <= RES_ABSENT;
								state_q <= S_FIN;
							end else begin
								present_q[a_in] <= 1'b1;
								pend_q <= RES_OK;
								state_q <= S_SWEEP;
							end
						end
						FN_DEL_V, FN_ADD_E, FN_DEL_E, FN_TEST_E, FN_CHECK_E: begin
							if (in_absent) begin
								pend_q <= RES_ABSENT;
								state_q <= S_FIN;
							end else if (func_t'(in_item.func) == FN_DEL_V) begin
								present_q[a_in] <= 1'b0;
								pend_q <= RES_OK;
								state_q <= S_SWEEP;
							end else begin
								pend_q <= RES_OK;
								state_q <= S_DEC;
							end
						end
						FN_SORT: begin
							visited_q <= '0;
							state_q <= S_SROOT;
						end
						default: begin
							pend_q <= RES_OK;
							state_q <= S_FIN;
						end
					endcase
				end
				S_SWEEP: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == CW'(VERTICES)) state_q <= S_FIN;
				end
				S_DEC: begin
					// wait for row a to be read
					if (!rd_wait_q) rd_wait_q <= 1'b1;
					else begin
						unique case (func_q)
							FN_TEST_E: begin
								pend_q.answer <= rd_q[b_q];
								state_q <= S_FIN;
							end
							FN_CHECK_E: begin
								reach_q <= rd_q | bbit;
								grown_q <= rd_q | bbit;
								idx_q <= '0;
								state_q <= S_CHK;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_CHK: begin
					if (idx_q == CW'(VERTICES)) begin
						idx_q <= '0;
						if (grown_mask == reach_q) begin
							pend_q.answer <= !reach_q[a_q];
							state_q <= S_FIN;
						end else begin
							reach_q <= grown_mask;
							grown_q <= grown_mask;
						end
					end else begin
						grown_q <= grown_acc;
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SROOT: begin
					if (idx_q == CW'(VERTICES)) begin
						pend_q <= RES_OK;
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + CW'(1);
						if (root_ok) begin
							visited_q[idx_q[AW-1:0]] <= 1'b1;
							v_q <= idx_q[AW-1:0];
							depth_q <= CW'(1);
							fresh_q <= 1'b1;
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: state_q <= S_SFIND;
				S_SFIND: begin
					if (push) begin
						visited_q[found_idx] <= 1'b1;
						depth_q <= depth_q + CW'(1);
						v_q <= found_idx;
						fresh_q <= 1'b1;
						state_q <= S_SRD;
					end else begin
						depth_q <= depth_q - CW'(1);
						pend_q <= '{status: 1'b0, answer: 1'b0, vertex_out: VW'(v_q),
							has_vertex: 1'b1, last: sort_last};
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (pend_q.last) state_q <= S_IDLE;
						else if (depth_q == '0) state_q <= S_SROOT;
						else state_q <= S_POP;
					end
				end
				S_POP: begin
					// stk_rd_q now holds the new top of the stack
					v_q <= stk_rd_q;
					fresh_q <= 1'b0;
					state_q <= S_SRD;
				end
				S_FIN: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> verif/dependency_graph_engine_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// dependency_graph_engine_tb
// Drives graph operations through the engine and compares every result item
// against an in-bench graph predictor, across several idling phases.
//------------------------------------------------------------------------------
module dependency_graph_engine_tb;
	import dge_pkg::*;

	localparam int NV = 32;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		func_t     fn;
		int        a;
		int        b;
		logic      fixed;
		out_item_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;

	logic [NV-1:0] g_present;
	logic [NV-1:0] g_rows [NV];
	out_item_t expected_q [$];
	out_item_t first_res;
	logic first_taken;
	row_t dir_rows [$];
	int fail_count = 0;
	int dir_fail_count;
	int cycle_count = 0;
	int send_idle_pct;
	int recv_stall_pct;

	dependency_graph_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic out_item_t mk(logic st, logic ans, logic [4:0] vx, logic hv, logic lst);
		out_item_t r;
		r.status = st;
		r.answer = ans;
		r.vertex_out = vx;
		r.has_vertex = hv;
		r.last = lst;
		return r;
	endfunction

	// Queues one expected item and keeps the first one of the current input.
	function automatic void expect_item(out_item_t x);
		if (!first_taken) begin
			first_res = x;
			first_taken = 1'b1;
		end
		expected_q = {expected_q, x};
	endfunction

	function automatic void clear_vertex_edges(int v);
		g_rows[v] = '0;
		for (int i = 0; i < NV; i++) g_rows[i][v] = 1'b0;
	endfunction

	function automatic logic may_add_edge(int a, int b);
		logic [NV-1:0] reach;
		logic [NV-1:0] grown;
		reach = g_rows[a];
		reach[b] = 1'b1;
		forever begin
			grown = reach;
			for (int i = 0; i < NV; i++)
				if (reach[i]) grown |= g_rows[i];
			grown &= g_present | (NV'(1) << b);
			if (grown == reach) break;
			reach = grown;
		end
		return !reach[a];
	endfunction

	// Post-order depth-first walk; roots and successors in ascending order.
	function automatic void predict_sort();
		logic [NV-1:0] seen;
		int stk [NV];
		int cur [NV];
		int depth;
		int v;
		int c;
		int n;
		logic found;
		seen = '0;
		n = 0;
		for (int root = 0; root < NV; root++) begin
			if (!g_present[root] || seen[root]) continue;
			stk[0] = root;
			cur[root] = 0;
			seen[root] = 1'b1;
			depth = 1;
			while (depth > 0) begin
				v = stk[depth-1];
				found = 1'b0;
				for (c = cur[v]; c < NV; c++)
					if (g_rows[v][c] && g_present[c] && !seen[c]) begin
						found = 1'b1;
						break;
					end
				if (found && depth < NV) begin
					cur[v] = c + 1;
					seen[c] = 1'b1;
					cur[c] = 0;
					stk[depth] = c;
					depth++;
				end else begin
					depth--;
					expect_item(mk(1'b0, 1'b0, v[4:0], 1'b1, 1'b0));
					n++;
				end
			end
		end
		if (n == 0) expect_item(mk(1'b0, 1'b0, 5'd0, 1'b0, 1'b1));
		else expected_q[$].last = 1'b1;
	endfunction

	function automatic void predict_graph_op(func_t fn, int a, int b);
		logic ans;
		ans = 1'b0;
		if (fn == FN_SORT) begin
			predict_sort();
			return;
		end
		if (fn == FN_NOP) begin
			expect_item(mk(1'b0, 1'b0, 5'd0, 1'b0, 1'b1));
			return;
		end
		if (fn == FN_ADD_V) begin
			clear_vertex_edges(a);
			g_present[a] = 1'b1;
			expect_item(mk(1'b0, 1'b0, 5'd0, 1'b0, 1'b1));
			return;
		end
		if (!g_present[a] || (fn != FN_DEL_V && !g_present[b])) begin
			expect_item(mk(1'b1, 1'b0, 5'd0, 1'b0, 1'b1));
			return;
		end
		case (fn)
			FN_DEL_V: begin
				clear_vertex_edges(a);
				g_present[a] = 1'b0;
			end
			FN_ADD_E: g_rows[a][b] = 1'b1;
			FN_DEL_E: g_rows[a][b] = 1'b0;
			FN_TEST_E: ans = g_rows[a][b];
			default: ans = may_add_edge(a, b);
		endcase
		expect_item(mk(1'b0, ans, 5'd0, 1'b0, 1'b1));
	endfunction

	task automatic send_op(func_t fn, int a, int b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item.func <= fn;
		in_item.vertex_a <= a[4:0];
		in_item.vertex_b <= b[4:0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		first_taken = 1'b0;
		predict_graph_op(fn, a, b);
	endtask

	// Receiver side: random stall, compare each accepted item.
	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with none expected: %p", $time, out_item);
					fail_count++;
				end else begin
					if (out_item !== expected_q[0]) begin
						$display("%0t: mismatch expected %p actual %p", $time,
							expected_q[0], out_item);
						fail_count++;
					end
					void'(expected_q.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic row_t r(func_t fn, int a, int b, logic fx, out_item_t res);
		row_t x;
		x.fn = fn; x.a = a; x.b = b; x.fixed = fx; x.res = res;
		return x;
	endfunction

	function automatic void add_row(row_t x);
		dir_rows = {dir_rows, x};
	endfunction

	// Picks a vertex mostly from a small pool so that graphs grow dense.
	function automatic int pick_vertex(int pool);
		if ($urandom_range(9) == 0) return $urandom_range(NV-1);
		return $urandom_range(pool-1);
	endfunction

	initial begin
		out_item_t ok;
		out_item_t absent;
		int pool;
		int k;
		func_t fn;
		ok = mk(1'b0, 1'b0, 5'd0, 1'b0, 1'b1);
		absent = mk(1'b1, 1'b0, 5'd0, 1'b0, 1'b1);
		dir_fail_count = 0;
		first_taken = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		g_present = '0;
		for (int i = 0; i < NV; i++) g_rows[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty sort, absent vertices, extremes, cycles, re-add.
		add_row(r(FN_SORT, 0, 0, 1'b1, ok));
		add_row(r(FN_NOP, 31, 31, 1'b1, ok));
		add_row(r(FN_DEL_V, 5, 0, 1'b1, absent));
		add_row(r(FN_ADD_E, 0, 31, 1'b1, absent));
		add_row(r(FN_ADD_V, 0, 0, 1'b1, ok));
		add_row(r(FN_ADD_V, 31, 0, 1'b1, ok));
		add_row(r(FN_ADD_V, 21, 0, 1'b1, ok));
		add_row(r(FN_ADD_V, 10, 0, 1'b1, ok));
		add_row(r(FN_CHECK_E, 0, 0, 1'b1, ok));
		add_row(r(FN_ADD_E, 0, 31, 1'b1, ok));
		add_row(r(FN_ADD_E, 0, 31, 1'b1, ok));
		add_row(r(FN_ADD_E, 31, 21, 1'b1, ok));
		add_row(r(FN_ADD_E, 21, 10, 1'b1, ok));
		add_row(r(FN_TEST_E, 0, 31, 1'b1, mk(1'b0, 1'b1, 5'd0, 1'b0, 1'b1)));
		add_row(r(FN_TEST_E, 31, 0, 1'b1, ok));
		add_row(r(FN_CHECK_E, 10, 0, 1'b0, ok));
		add_row(r(FN_CHECK_E, 0, 10, 1'b0, ok));
		add_row(r(FN_ADD_E, 10, 0, 1'b1, ok));
		add_row(r(FN_CHECK_E, 0, 21, 1'b0, ok));
		add_row(r(FN_SORT, 0, 0, 1'b0, ok));
		add_row(r(FN_DEL_E, 0, 21, 1'b1, ok));
		add_row(r(FN_ADD_V, 21, 0, 1'b1, ok));
		add_row(r(FN_TEST_E, 31, 21, 1'b1, ok));
		add_row(r(FN_DEL_V, 31, 0, 1'b1, ok));
		add_row(r(FN_SORT, 0, 0, 1'b0, ok));
		foreach (dir_rows[i]) begin
			send_op(dir_rows[i].fn, dir_rows[i].a, dir_rows[i].b);
			if (dir_rows[i].fixed && first_res !== dir_rows[i].res) begin
				$display("%0t: row %0d expected %p actual %p", $time, i,
					dir_rows[i].res, first_res);
				dir_fail_count++;
			end
		end

		// Random part in idling phases; pools vary between few and all vertices.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				3: begin send_idle_pct = 16; recv_stall_pct = 16; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			pool = (ph == 4) ? NV : 4 + 3 * ph;
			for (int n = 0; n < 74; n++) begin
				k = $urandom_range(99);
				if (k < 18) fn = FN_ADD_V;
				else if (k < 24) fn = FN_DEL_V;
				else if (k < 52) fn = FN_ADD_E;
				else if (k < 58) fn = FN_DEL_E;
				else if (k < 70) fn = FN_TEST_E;
				else if (k < 86) fn = FN_CHECK_E;
				else if (k < 96) fn = FN_SORT;
				else fn = FN_NOP;
				send_op(fn, pick_vertex(pool), pick_vertex(pool));
			end
		end
		// Fill every vertex for a full-size sort and all bits of the fields.
		for (int v = 0; v < NV; v++) send_op(FN_ADD_V, v, 0);
		for (int v = 1; v < NV; v++) send_op(FN_ADD_E, v - 1, v);
		send_op(FN_CHECK_E, NV - 1, 0);
		send_op(FN_SORT, 0, 0);
		in_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (fail_count == 0 && dir_fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> dependency_graph_engine.f
hw/rtl/dge_pkg.sv
hw/rtl/dependency_graph_engine.sv
verif/dependency_graph_engine_tb.sv
